/* rtl/core/mbtcp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the Modbus TCP request parser.
// No dependencies; imported by every module of the block.
package mbtcp_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 16;
  localparam int TDATA_W = 96;
  localparam int OQ_DEPTH = 4;

  // Byte offsets within the frame
  localparam int OFS_TID_HI  = 0;
  localparam int OFS_TID_LO  = 1;
  localparam int OFS_LEN_HI  = 4;
  localparam int OFS_LEN_LO  = 5;
  localparam int OFS_UNIT    = 6;
  localparam int OFS_FUNC    = 7;
  localparam int OFS_ADDR_HI = 8;
  localparam int OFS_ADDR_LO = 9;
  localparam int OFS_QTY_HI  = 10;
  localparam int OFS_QTY_LO  = 11;
  localparam int OFS_BCNT    = 12;
  localparam int OFS_DATA    = 13;
  localparam int MBAP_PREFIX = 6;

  // Function codes
  localparam logic [7:0] FC_READ_COILS      = 8'd1;
  localparam logic [7:0] FC_READ_INPUT_REGS = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL      = 8'd5;
  localparam logic [7:0] FC_WRITE_REG       = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS     = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS      = 8'd16;

  localparam logic [7:0] VALUE_LIMIT = 8'd255;

  typedef enum logic {
    KIND_VALUE   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] transaction_id;
    logic [7:0]  unit_id;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] item_quantity;
    logic [15:0] payload_value;
    logic [7:0]  value_index;
    logic        length_ok;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_ctl_t;

  function automatic logic is_single(input logic [7:0] f);
    return (f == FC_WRITE_COIL) || (f == FC_WRITE_REG);
  endfunction

  function automatic logic is_known(input logic [7:0] f);
    return f inside {[FC_READ_COILS:FC_WRITE_REG], FC_WRITE_COILS, FC_WRITE_REGS};
  endfunction

endpackage

/* rtl/core/mbtcp_parse.sv */
`timescale 1ns / 1ps
// Frame byte counter, header registers and per-beat result builder.
// Depends on mbtcp_pkg.
module mbtcp_parse
  import mbtcp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 512,
  localparam int PW = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       frame_end,
  output push_ctl_t  push,
  output result_t    res0,
  output result_t    res1
);

  logic [PW-1:0] byte_position, byte_position_next;
  logic [15:0]   transaction_reg, transaction_reg_next;
  logic [15:0]   length_reg, length_reg_next;
  logic [7:0]    unit_reg, unit_reg_next;
  logic [7:0]    function_reg, function_reg_next;
  logic [15:0]   address_reg, address_reg_next;
  logic [15:0]   quantity_reg, quantity_reg_next;
  logic [7:0]    high_byte_hold, high_byte_hold_next;
  logic [7:0]    value_count, value_count_next;

  logic          active;
  logic [15:0]   word;
  logic          emit_val;
  logic [15:0]   val_data;
  logic          len_ok;
  result_t       val_res, sum_res;

  assign active = byte_position < PW'(MAX_FRAME_BYTES);
  assign word   = {high_byte_hold, data_byte};

  always_comb begin
    byte_position_next   = byte_position;
    transaction_reg_next = transaction_reg;
    length_reg_next      = length_reg;
    unit_reg_next        = unit_reg;
    function_reg_next    = function_reg;
    address_reg_next     = address_reg;
    quantity_reg_next    = quantity_reg;
    high_byte_hold_next  = high_byte_hold;
    value_count_next     = value_count;
    emit_val             = 1'b0;
    val_data             = '0;
    if (active) begin
      byte_position_next = byte_position + PW'(1);
      case (byte_position)
        PW'(OFS_TID_HI), PW'(OFS_LEN_HI), PW'(OFS_ADDR_HI), PW'(OFS_QTY_HI): begin
          high_byte_hold_next = data_byte;
        end
        PW'(OFS_TID_LO): transaction_reg_next = word;
        PW'(OFS_LEN_LO): length_reg_next = word;
        PW'(OFS_UNIT):   unit_reg_next = data_byte;
        PW'(OFS_FUNC): begin
          function_reg_next = data_byte;
          if (is_single(data_byte)) quantity_reg_next = 16'd1;
        end
        PW'(OFS_ADDR_LO): begin
          if (is_known(function_reg)) address_reg_next = word;
        end
        PW'(OFS_QTY_LO): begin
          if (is_single(function_reg)) begin
            emit_val         = 1'b1;
            val_data         = word;
            value_count_next = 8'd1;
          end else if (is_known(function_reg)) begin
            quantity_reg_next = word;
          end
        end
        PW'(OFS_BCNT): begin
          if (function_reg == FC_WRITE_COILS) high_byte_hold_next = data_byte;
        end
        default: begin
          if (byte_position >= PW'(OFS_DATA)) begin
            if (function_reg == FC_WRITE_COILS) begin
              if (value_count < high_byte_hold) begin
                emit_val         = 1'b1;
                val_data         = {8'd0, data_byte};
                value_count_next = value_count + 8'd1;
              end
            end else if (function_reg == FC_WRITE_REGS) begin
              if (byte_position[0]) begin
                high_byte_hold_next = data_byte;
              end else if ((16'(value_count) < quantity_reg) &&
                           (value_count != VALUE_LIMIT)) begin
                emit_val         = 1'b1;
                val_data         = word;
                value_count_next = value_count + 8'd1;
              end
            end
          end
        end
      endcase
    end
  end

  assign len_ok = active && (byte_position >= PW'(MBAP_PREFIX - 1)) &&
                  (length_reg_next == 16'(byte_position) - 16'(MBAP_PREFIX - 1));

  always_comb begin
    val_res.kind           = KIND_VALUE;
    val_res.transaction_id = transaction_reg_next;
    val_res.unit_id        = unit_reg_next;
    val_res.function_code  = function_reg_next;
    val_res.start_address  = address_reg_next;
    val_res.item_quantity  = quantity_reg_next;
    val_res.payload_value  = val_data;
    val_res.value_index    = value_count;
    val_res.length_ok      = 1'b0;
    val_res.last_result    = 1'b0;

    sum_res                = val_res;
    sum_res.kind           = KIND_SUMMARY;
    sum_res.payload_value  = '0;
    sum_res.value_index    = value_count_next;
    sum_res.length_ok      = len_ok;
    sum_res.last_result    = 1'b1;
  end

  assign res0        = emit_val ? val_res : sum_res;
  assign res1        = sum_res;
  assign push.first  = accept & (emit_val | frame_end);
  assign push.second = accept & emit_val & frame_end;

  always_ff @(posedge clk) begin
    if (rst || (accept && frame_end)) begin
      byte_position   <= '0;
      transaction_reg <= '0;
      length_reg      <= '0;
      unit_reg        <= '0;
      function_reg    <= '0;
      address_reg     <= '0;
      quantity_reg    <= '0;
      high_byte_hold  <= '0;
      value_count     <= '0;
    end else if (accept) begin
      byte_position   <= byte_position_next;
      transaction_reg <= transaction_reg_next;
      length_reg      <= length_reg_next;
      unit_reg        <= unit_reg_next;
      function_reg    <= function_reg_next;
      address_reg     <= address_reg_next;
      quantity_reg    <= quantity_reg_next;
      high_byte_hold  <= high_byte_hold_next;
      value_count     <= value_count_next;
    end
  end

endmodule

/* rtl/core/mbtcp_outq.sv */
`timescale 1ns / 1ps
// Result queue: takes up to two results per beat, hands out one per beat.
// Depends on mbtcp_pkg.
module mbtcp_outq
  import mbtcp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  push_ctl_t push,
  input  result_t   res0,
  input  result_t   res1,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_res
);

  localparam int AW = $clog2(OQ_DEPTH);
  localparam int CW = $clog2(OQ_DEPTH + 1);

  result_t       mem [OQ_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count, count_next;
  logic          pop;
  logic [1:0]    n_push;

  assign out_valid = count != '0;
  assign room      = count <= CW'(OQ_DEPTH - 2);
  assign pop       = out_valid & out_ready;
  assign out_res   = mem[rd_ptr];
  assign n_push    = {1'b0, push.first} + {1'b0, push.second};
  assign count_next = count + CW'(n_push) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push.first)  mem[wr_ptr] <= res0;
    if (push.second) mem[wr_ptr + AW'(1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(n_push);
      if (pop) rd_ptr <= rd_ptr + AW'(1);
      count <= count_next;
    end
  end

endmodule

/* rtl/core/modbus_tcp_request_parser_top.sv */
`timescale 1ns / 1ps
// Modbus TCP request parser, top level.
// Depends on mbtcp_pkg, mbtcp_parse and mbtcp_outq.
//
// Usage:
//   s_axis carries the request frame, one byte per beat in tdata[7:0];
//   tlast marks the frame's final byte.
//   m_axis carries results: tuser is the kind (0 value, 1 frame summary),
//   tlast marks the final result of a frame, tdata holds the header fields,
//   the value, its index and the length check.
//   A result enters the result queue as its byte is taken and is presented
//   once the results ahead of it have gone. Throughput: one byte per cycle
//   while s_axis_tready is high. A byte may cause two results (a value and
//   the summary); the output side then needs two beats, absorbed by a
//   four-entry result queue. s_axis_tready drops when fewer than two queue
//   entries are free. Stall: while m_axis_tready is low, results wait in
//   the queue and input is taken until fewer than two entries are free.
//   Reset (rst, synchronous): clears the byte counter, header registers and
//   the queue; the next byte is taken as the first byte of a frame.
module modbus_tcp_request_parser_top
  import mbtcp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // [7:0] data_byte
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [15:0] transaction_id, [23:16] unit_id, [31:24] function_code,
  // [47:32] start_address, [63:48] item_quantity, [79:64] payload_value,
  // [87:80] value_index, [88] length_ok, [95:89] zero
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic               m_axis_tuser,  // [0] kind
  output logic               m_axis_tlast
);

  push_ctl_t push;
  result_t   res0, res1, head;
  logic      room;
  logic      accept;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid & room;

  mbtcp_parse #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .data_byte(s_axis_tdata),
    .frame_end(s_axis_tlast),
    .push     (push),
    .res0     (res0),
    .res1     (res1)
  );

  mbtcp_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .res0     (res0),
    .res1     (res1),
    .room     (room),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_res  (head)
  );

  assign m_axis_tdata = {7'd0, head.length_ok, head.value_index, head.payload_value,
                         head.item_quantity, head.start_address, head.function_code,
                         head.unit_id, head.transaction_id};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last_result;

endmodule

/* tb/modbus_tcp_request_parser_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for modbus_tcp_request_parser_top: drives request frames byte by byte
// and checks every result beat against an in-bench frame parser. Depends on mbtcp_pkg and the RTL.
module modbus_tcp_request_parser_top_tb;
  import mbtcp_pkg::*;

  localparam int FRAME_LIMIT = 512;
  localparam int TARGET_BYTES = 1500;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    result_t    exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  bit beat_typed = 1'b0;
  result_t beat_exp = '0;
  bit calm = 1'b0;

  int mb_pos;
  logic [15:0] mb_tid, mb_len, mb_addr, mb_qty;
  logic [7:0] mb_unit, mb_fc, mb_hold, mb_nvals;

  result_t pending_results[$];
  stim_row_t directed_rows[$];
  logic [7:0] frame_q[$];

  int errors = 0;
  int parsed_bytes = 0;
  int frames_sent = 0;
  int results_seen = 0;
  int values_seen = 0;
  longint cycles = 0;

  modbus_tcp_request_parser_top #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic bit single_write(logic [7:0] f);
    return f == FC_WRITE_COIL || f == FC_WRITE_REG;
  endfunction

  function automatic bit supported_fc(logic [7:0] f);
    return (f >= FC_READ_COILS && f <= FC_WRITE_REG) || f == FC_WRITE_COILS ||
           f == FC_WRITE_REGS;
  endfunction

  function void clear_parser();
    mb_pos = 0;
    mb_tid = '0;
    mb_len = '0;
    mb_unit = '0;
    mb_fc = '0;
    mb_addr = '0;
    mb_qty = '0;
    mb_hold = '0;
    mb_nvals = '0;
  endfunction

  function void queue_result(kind_t k, logic [15:0] v, logic [7:0] idx, logic ok);
    result_t r;
    r = '0;
    r.kind = k;
    r.transaction_id = mb_tid;
    r.unit_id = mb_unit;
    r.function_code = mb_fc;
    r.start_address = mb_addr;
    r.item_quantity = mb_qty;
    r.payload_value = v;
    r.value_index = idx;
    r.length_ok = ok;
    r.last_result = (k == KIND_SUMMARY);
    pending_results.push_back(r);
  endfunction

  function void parse_byte(logic [7:0] b, logic last);
    logic [15:0] word;
    logic [7:0] f;
    int pos;
    logic ok;
    pos = mb_pos;
    word = {mb_hold, b};
    f = mb_fc;
    if (pos < FRAME_LIMIT) begin
      parsed_bytes++;
      case (pos)
        OFS_TID_HI, OFS_LEN_HI, OFS_ADDR_HI, OFS_QTY_HI: mb_hold = b;
        OFS_TID_LO: mb_tid = word;
        OFS_LEN_LO: mb_len = word;
        OFS_UNIT: mb_unit = b;
        OFS_FUNC: begin
          mb_fc = b;
          if (single_write(b)) mb_qty = 16'd1;
        end
        OFS_ADDR_LO: if (supported_fc(f)) mb_addr = word;
        OFS_QTY_LO: begin
          if (single_write(f)) begin
            queue_result(KIND_VALUE, word, 8'd0, 1'b0);
            mb_nvals = 8'd1;
          end else if (supported_fc(f)) begin
            mb_qty = word;
          end
        end
        OFS_BCNT: if (f == FC_WRITE_COILS) mb_hold = b;
        default: begin
          if (pos >= OFS_DATA && f == FC_WRITE_COILS) begin
            if (mb_nvals < mb_hold) begin
              queue_result(KIND_VALUE, {8'd0, b}, mb_nvals, 1'b0);
              mb_nvals++;
            end
          end else if (pos >= OFS_DATA && f == FC_WRITE_REGS) begin
            if (((pos - OFS_DATA) % 2) == 0) begin
              mb_hold = b;
            end else if (16'(mb_nvals) < mb_qty && mb_nvals < VALUE_LIMIT) begin
              queue_result(KIND_VALUE, word, mb_nvals, 1'b0);
              mb_nvals++;
            end
          end
        end
      endcase
      mb_pos = pos + 1;
    end
    if (last) begin
      ok = pos < FRAME_LIMIT && pos + 1 >= MBAP_PREFIX &&
           int'(mb_len) == pos + 1 - MBAP_PREFIX;
      queue_result(KIND_SUMMARY, 16'd0, mb_nvals, ok);
      clear_parser();
    end
  endfunction

  function void check_field(string nm, logic [15:0] e, logic [15:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, nm, e, a);
    end
  endfunction

  always @(posedge clk) begin
    result_t exp;
    int n0;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        n0 = pending_results.size();
        parse_byte(s_axis_tdata, s_axis_tlast);
        if (beat_typed) begin
          while (pending_results.size() > n0) void'(pending_results.pop_back());
          pending_results.push_back(beat_exp);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (!m_axis_tuser) values_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, tdata %0h", $time, m_axis_tdata);
        end else begin
          exp = pending_results.pop_front();
          check_field("kind", 16'(exp.kind), 16'(m_axis_tuser));
          check_field("transaction_id", exp.transaction_id, m_axis_tdata[15:0]);
          check_field("unit_id", 16'(exp.unit_id), 16'(m_axis_tdata[23:16]));
          check_field("function_code", 16'(exp.function_code), 16'(m_axis_tdata[31:24]));
          check_field("start_address", exp.start_address, m_axis_tdata[47:32]);
          check_field("item_quantity", exp.item_quantity, m_axis_tdata[63:48]);
          check_field("payload_value", exp.payload_value, m_axis_tdata[79:64]);
          check_field("value_index", 16'(exp.value_index), 16'(m_axis_tdata[87:80]));
          check_field("length_ok", 16'(exp.length_ok), 16'(m_axis_tdata[88]));
          check_field("last_result", 16'(exp.last_result), 16'(m_axis_tlast));
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  initial begin
    int g;
    @(negedge rst);
    forever begin
      m_axis_tready <= 1'b1;
      repeat (pick_gap() + 1) @(negedge clk);
      g = calm ? 0 : pick_gap();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  task automatic send_beat(logic [7:0] b, logic last, bit typed, result_t exp);
    int g;
    g = calm ? 0 : pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    beat_typed <= typed;
    beat_exp <= exp;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_beat(frame_q[i], i == frame_q.size() - 1, 1'b0, '0);
    frames_sent++;
    calm = ($urandom_range(0, 5) == 0);
  endtask

  function void add_row(logic [7:0] d, logic l);
    directed_rows.push_back('{data: d, last: l, typed: 1'b0, exp: '0});
  endfunction

  function void add_typed(logic [15:0] tid, logic [7:0] fc, logic ok, logic [7:0] d);
    result_t r;
    r = '0;
    r.kind = KIND_SUMMARY;
    r.transaction_id = tid;
    r.function_code = fc;
    r.length_ok = ok;
    r.last_result = 1'b1;
    directed_rows.push_back('{data: d, last: 1'b1, typed: 1'b1, exp: r});
  endfunction

  task automatic build_frame();
    logic [7:0] fc;
    logic [15:0] q;
    logic [15:0] total;
    int sel;
    int n;
    int k;
    frame_q.delete();
    sel = $urandom_range(0, 11);
    if (sel == 11) begin
      repeat ($urandom_range(1, 20)) frame_q.push_back(8'($urandom));
      return;
    end
    case (sel)
      0, 1, 2, 3: fc = 8'($urandom_range(FC_READ_COILS, FC_READ_INPUT_REGS));
      4: fc = FC_WRITE_COIL;
      5: fc = FC_WRITE_REG;
      6, 7: fc = FC_WRITE_COILS;
      8, 9: fc = FC_WRITE_REGS;
      default: begin
        fc = 8'($urandom);
        if (supported_fc(fc)) fc = fc ^ 8'h80;
      end
    endcase
    repeat (4) frame_q.push_back(8'($urandom));
    frame_q.push_back(8'd0);
    frame_q.push_back(8'd0);
    frame_q.push_back(8'($urandom));
    frame_q.push_back(fc);
    repeat (2) frame_q.push_back(8'($urandom));
    if (fc == FC_WRITE_COILS) begin
      repeat (2) frame_q.push_back(8'($urandom));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
      frame_q.push_back(n[7:0]);
      k = (n > 6) ? n : n + $urandom_range(0, 3);
      repeat (k) frame_q.push_back(8'($urandom));
    end else if (fc == FC_WRITE_REGS) begin
      q = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      k = (q <= 6) ? q + $urandom_range(0, 2) : $urandom_range(0, 8);
      frame_q.push_back(q[15:8]);
      frame_q.push_back(q[7:0]);
      frame_q.push_back(8'(2 * k));
      repeat (2 * k + $urandom_range(0, 1)) frame_q.push_back(8'($urandom));
    end else begin
      repeat (2) frame_q.push_back(8'($urandom));
      if (!supported_fc(fc)) repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom));
    end
    total = 16'(frame_q.size() - MBAP_PREFIX);
    if ($urandom_range(0, 7) == 0) total = 16'($urandom);
    frame_q[OFS_LEN_HI] = total[15:8];
    frame_q[OFS_LEN_LO] = total[7:0];
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, frame_q.size());
      while (frame_q.size() > n) void'(frame_q.pop_back());
    end
  endtask

  task automatic build_overlong_frame();
    logic [15:0] total;
    frame_q.delete();
    repeat (4) frame_q.push_back(8'($urandom));
    frame_q.push_back(8'd0);
    frame_q.push_back(8'd0);
    frame_q.push_back(8'($urandom));
    frame_q.push_back(FC_WRITE_REGS);
    repeat (2) frame_q.push_back(8'($urandom));
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'hFE);
    while (frame_q.size() < FRAME_LIMIT + 18) frame_q.push_back(8'($urandom));
    total = 16'(frame_q.size() - MBAP_PREFIX);
    frame_q[OFS_LEN_HI] = total[15:8];
    frame_q[OFS_LEN_LO] = total[7:0];
  endtask

  initial begin
    clear_parser();
    // one-byte frame after reset
    add_typed(16'h0000, 8'h00, 1'b0, 8'hFF);
    // five bytes, transaction id all ones, too short for the length check
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    repeat (2) add_row(8'h00, 1'b0);
    add_typed(16'hFFFF, 8'h00, 1'b0, 8'h00);
    // write single register at full scale: value and summary from one byte
    repeat (5) add_row(8'h00, 1'b0);
    add_row(8'h06, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(FC_WRITE_REG, 1'b0);
    repeat (3) add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b1);
    // unknown function code, header only
    repeat (5) add_row(8'h00, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h00, 1'b0);
    add_typed(16'h0000, 8'h80, 1'b1, 8'h80);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].exp);
    frames_sent += 4;

    while (parsed_bytes < TARGET_BYTES) begin
      if (frames_sent == 40) build_overlong_frame();
      else build_frame();
      send_frame();
    end
    s_axis_tvalid <= 1'b0;
    beat_typed <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end

    $display("Sent %0d frames (%0d parsed bytes): reads, single and multiple writes,",
             frames_sent, parsed_bytes);
    $display("unknown codes, truncated, noisy and overlong frames; %0d results (%0d values),",
             results_seen, values_seen);
    $display("%0d errors", errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/mbtcp_pkg.sv
rtl/core/mbtcp_parse.sv
rtl/core/mbtcp_outq.sv
rtl/core/modbus_tcp_request_parser_top.sv
tb/modbus_tcp_request_parser_top_tb.sv
